// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: design/ipp_pkg.sv
// ----------------------------------------------------------------------------
// ipp_pkg
// Types, codes and small decode functions of the IPP message byte parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipp_pkg;

  // Parse phases; codes above the trailing phase act as trailing data
  typedef enum logic [3:0] {
    PH_VERSION = 4'd0,
    PH_OPSTAT  = 4'd1,
    PH_REQID   = 4'd2,
    PH_TAG     = 4'd3,
    PH_NLEN    = 4'd4,
    PH_NAME    = 4'd5,
    PH_VLEN    = 4'd6,
    PH_VALUE   = 4'd7,
    PH_TRAIL   = 4'd8
  } phase_t;

  // Role given to each byte
  typedef enum logic [3:0] {
    ROLE_VERSION = 4'd0,
    ROLE_OPSTAT  = 4'd1,
    ROLE_REQID   = 4'd2,
    ROLE_GROUP   = 4'd3,
    ROLE_END     = 4'd4,
    ROLE_VTAG    = 4'd5,
    ROLE_NLEN    = 4'd6,
    ROLE_NAME    = 4'd7,
    ROLE_VLEN    = 4'd8,
    ROLE_VALUE   = 4'd9,
    ROLE_TRAIL   = 4'd10
  } role_t;

  // Response status classes
  localparam logic [2:0] CLS_OK       = 3'd0;
  localparam logic [2:0] CLS_INFO     = 3'd1;
  localparam logic [2:0] CLS_REDIRECT = 3'd2;
  localparam logic [2:0] CLS_CLIENT   = 3'd3;
  localparam logic [2:0] CLS_SERVER   = 3'd4;
  localparam logic [2:0] CLS_UNKNOWN  = 3'd5;

  // Tag types
  localparam logic [2:0] TT_DELIM   = 3'd0;
  localparam logic [2:0] TT_INTEGER = 3'd1;
  localparam logic [2:0] TT_OCTET   = 3'd2;
  localparam logic [2:0] TT_CHAR    = 3'd3;
  localparam logic [2:0] TT_OTHER   = 3'd4;

  // Tag bytes and their high nibbles
  localparam logic [7:0] TAG_END       = 8'h03;
  localparam logic [3:0] NIB_DELIM     = 4'h0;
  localparam logic [3:0] NIB_INTEGER   = 4'h2;
  localparam logic [3:0] NIB_OCTET     = 4'h3;
  localparam logic [3:0] NIB_CHAR      = 4'h4;

  // Status code high bytes
  localparam logic [7:0] CODE_OK       = 8'h00;
  localparam logic [7:0] CODE_INFO     = 8'h01;
  localparam logic [7:0] CODE_REDIRECT = 8'h02;
  localparam logic [7:0] CODE_CLIENT   = 8'h04;
  localparam logic [7:0] CODE_SERVER   = 8'h05;

  // Fixed field sizes in bytes
  localparam logic [15:0] SIZE_SHORT = 16'd2;
  localparam logic [15:0] SIZE_LONG  = 16'd4;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 48;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       request_flag;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] bytes_left;
    logic [15:0] value_length_held;
    logic [31:0] accumulator;
    logic [7:0]  current_tag;
    logic        request_mode;
  } state_t;

  // Packed in the order of the output tdata, lowest field last
  typedef struct packed {
    logic [1:0]  pad;
    logic        truncated;
    logic        bad_integer_length;
    logic        additional_value;
    logic [2:0]  tag_kind;
    logic [2:0]  status_class;
    logic [31:0] field_value;
    logic        field_done;
    role_t       byte_role;
  } result_t;

  function automatic logic [2:0] class_of(input logic [7:0] code_hi);
    logic [2:0] cls;
    unique case (code_hi)
      CODE_OK:       cls = CLS_OK;
      CODE_INFO:     cls = CLS_INFO;
      CODE_REDIRECT: cls = CLS_REDIRECT;
      CODE_CLIENT:   cls = CLS_CLIENT;
      CODE_SERVER:   cls = CLS_SERVER;
      default:       cls = CLS_UNKNOWN;
    endcase
    return cls;
  endfunction

  function automatic logic [2:0] type_of(input logic [7:0] tag);
    logic [2:0] tt;
    unique case (tag[7:4])
      NIB_DELIM:   tt = TT_DELIM;
      NIB_INTEGER: tt = TT_INTEGER;
      NIB_OCTET:   tt = TT_OCTET;
      NIB_CHAR:    tt = TT_CHAR;
      default:     tt = TT_OTHER;
    endcase
    return tt;
  endfunction

endpackage

// File: design/ipp_in_stage.sv
// ----------------------------------------------------------------------------
// ipp_in_stage
// Input register: holds one accepted item until the parse step takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipp_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  ipp_pkg::item_t item_in,
  input  logic           advance,
  output logic           ready,
  output logic           held_valid,
  output ipp_pkg::item_t held_item
);
  import ipp_pkg::*;

  // Free when empty or when the held item moves on this cycle
  assign ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_item <= item_in;
    end
  end

endmodule

// File: design/ipp_step.sv
// ----------------------------------------------------------------------------
// ipp_step
// Parse step: next parser state and the result for one message byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipp_step (
  input  ipp_pkg::item_t   item,
  input  ipp_pkg::state_t  cur,
  output ipp_pkg::state_t  nxt,
  output ipp_pkg::result_t res
);
  import ipp_pkg::*;

  state_t      s;
  logic [7:0]  b;
  logic [31:0] fix_acc;
  logic [15:0] fix_cnt;
  logic [31:0] shift_acc;
  logic [15:0] dec_cnt;
  role_t       role;
  logic        done;
  logic [31:0] val;
  logic [2:0]  sc;
  logic        av;
  logic        bad;
  logic        is_int;

  always_comb begin
    // Restart on the first byte of a message
    s = cur;
    if (item.first_byte) begin
      s.phase             = PH_VERSION;
      s.bytes_left        = '0;
      s.value_length_held = '0;
      s.accumulator       = '0;
      s.current_tag       = '0;
      s.request_mode      = item.request_flag;
    end

    b         = item.data_byte;
    fix_acc   = (s.bytes_left == 16'd0) ? {24'd0, b} : {s.accumulator[23:0], b};
    fix_cnt   = s.bytes_left + 16'd1;
    shift_acc = {s.accumulator[23:0], b};
    dec_cnt   = s.bytes_left - 16'd1;
    is_int    = (s.current_tag[7:4] == NIB_INTEGER);

    nxt  = s;
    role = ROLE_TRAIL;
    done = 1'b0;
    val  = '0;
    sc   = CLS_OK;
    av   = 1'b0;
    bad  = 1'b0;

    unique case (s.phase)
      PH_VERSION: begin
        role            = ROLE_VERSION;
        nxt.accumulator = fix_acc;
        if (fix_cnt >= SIZE_SHORT) begin
          nxt.bytes_left = '0;
          done           = 1'b1;
          val            = fix_acc;
          nxt.phase      = PH_OPSTAT;
        end else begin
          nxt.bytes_left = fix_cnt;
        end
      end
      PH_OPSTAT: begin
        role            = ROLE_OPSTAT;
        nxt.accumulator = fix_acc;
        if (fix_cnt >= SIZE_SHORT) begin
          nxt.bytes_left = '0;
          done           = 1'b1;
          val            = fix_acc;
          if (!s.request_mode) begin
            sc = (fix_acc[31:16] == 16'd0) ? class_of(fix_acc[15:8]) : CLS_UNKNOWN;
          end
          nxt.phase = PH_REQID;
        end else begin
          nxt.bytes_left = fix_cnt;
        end
      end
      PH_REQID: begin
        role            = ROLE_REQID;
        nxt.accumulator = fix_acc;
        if (fix_cnt >= SIZE_LONG) begin
          nxt.bytes_left = '0;
          done           = 1'b1;
          val            = fix_acc;
          nxt.phase      = PH_TAG;
        end else begin
          nxt.bytes_left = fix_cnt;
        end
      end
      PH_TAG: begin
        nxt.current_tag = b;
        if (b[7:4] == NIB_DELIM) begin
          if (b == TAG_END) begin
            role      = ROLE_END;
            nxt.phase = PH_TRAIL;
          end else begin
            role = ROLE_GROUP;
          end
        end else begin
          role           = ROLE_VTAG;
          nxt.bytes_left = '0;
          nxt.phase      = PH_NLEN;
        end
      end
      PH_NLEN: begin
        role            = ROLE_NLEN;
        nxt.accumulator = fix_acc;
        if (fix_cnt >= SIZE_SHORT) begin
          nxt.bytes_left = '0;
          done           = 1'b1;
          val            = fix_acc;
          if (fix_acc == 32'd0) begin
            av        = 1'b1;
            nxt.phase = PH_VLEN;
          end else begin
            nxt.bytes_left = fix_acc[15:0];
            nxt.phase      = PH_NAME;
          end
        end else begin
          nxt.bytes_left = fix_cnt;
        end
      end
      PH_NAME: begin
        role = ROLE_NAME;
        if (s.bytes_left <= 16'd1) begin
          nxt.bytes_left = '0;
          nxt.phase      = PH_VLEN;
        end else begin
          nxt.bytes_left = dec_cnt;
        end
      end
      PH_VLEN: begin
        role            = ROLE_VLEN;
        nxt.accumulator = fix_acc;
        if (fix_cnt >= SIZE_SHORT) begin
          nxt.bytes_left        = '0;
          done                  = 1'b1;
          val                   = fix_acc;
          nxt.value_length_held = fix_acc[15:0];
          bad                   = is_int && (fix_acc[15:0] != SIZE_LONG);
          if (fix_acc[15:0] == 16'd0) begin
            nxt.phase = PH_TAG;
          end else begin
            nxt.bytes_left  = fix_acc[15:0];
            nxt.accumulator = '0;
            nxt.phase       = PH_VALUE;
          end
        end else begin
          nxt.bytes_left = fix_cnt;
        end
      end
      PH_VALUE: begin
        role            = ROLE_VALUE;
        nxt.accumulator = shift_acc;
        if (s.bytes_left <= 16'd1) begin
          nxt.bytes_left = '0;
          if (is_int && (s.value_length_held == SIZE_LONG)) begin
            done = 1'b1;
            val  = shift_acc;
          end
          nxt.phase = PH_TAG;
        end else begin
          nxt.bytes_left = dec_cnt;
        end
      end
      default: begin
        role = ROLE_TRAIL;
      end
    endcase

    res.pad                = '0;
    res.byte_role          = role;
    res.field_done         = done;
    res.field_value        = val;
    res.status_class       = sc;
    res.tag_kind           = type_of(nxt.current_tag);
    res.additional_value   = av;
    res.bad_integer_length = bad;
    res.truncated          = item.last_byte && (nxt.phase != PH_TAG)
                             && (nxt.phase < PH_TRAIL);
  end

endmodule

// File: design/ipp_message_byte_parser.sv
// Path: an accepted input item waits in the input register, and the parse
// step moves it into the result register once that register is free or drains.
// Throughput: one item per cycle while results are taken; the input register
// refills as the parse step moves its item into the result register. A held
// result holds the parse step, the input register then fills and s_tready drops.
// Reset (rst, synchronous, active high): parser to the version phase as a response.
// ----------------------------------------------------------------------------
// ipp_message_byte_parser
// Classifies each byte of an IPP message and reports completed header and
// attribute fields, status class, tag type and error flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipp_message_byte_parser (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ipp_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] data_byte
  input  logic                              s_tlast,   // last_byte
  input  logic [ipp_pkg::IN_USER_W-1:0]     s_tuser,   // [0] first_byte, [1] request_flag
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [3:0] byte_role, [4] field_done, [36:5] field_value, [39:37] status_class,
  // [42:40] tag_kind, [43] additional_value, [44] bad_integer_length,
  // [45] truncated, [47:46] zero
  output logic [ipp_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import ipp_pkg::*;

  item_t   item_in;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    advance;
  state_t  st;
  state_t  st_next;
  result_t step_res;
  result_t res;

  // Gather the input item from the bus fields
  assign item_in.data_byte    = s_tdata[7:0];
  assign item_in.first_byte   = s_tuser[0];
  assign item_in.request_flag = s_tuser[1];
  assign item_in.last_byte    = s_tlast;

  assign take = s_tvalid && s_tready;

  // Advance the held item whenever the result register is free or drains now
  assign advance = held_valid && (!m_tvalid || m_tready);

  ipp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .item_in    (item_in),
    .advance    (advance),
    .ready      (s_tready),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ipp_step u_step (
    .item (held_item),
    .cur  (st),
    .nxt  (st_next),
    .res  (step_res)
  );

  // Parser state: commit only when an item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase             <= PH_VERSION;
      st.bytes_left        <= '0;
      st.value_length_held <= '0;
      st.accumulator       <= '0;
      st.current_tag       <= '0;
      st.request_mode      <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign m_tdata = res;

endmodule

// File: design/ipp_checker.sv
// ----------------------------------------------------------------------------
// ipp_checker
// Port-level checks of the IPP message byte parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ipp_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ipp_pkg::*;

  result_t r;

  assign r = m_tdata;

  // A stalled result stays put
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // No value without a completed field
  `ASSERT_IMPLIES(a_value_zero, clk, rst, m_tvalid && !r.field_done, r.field_value == 32'd0)

  // A status class only on the byte that completes the status code
  `ASSERT_IMPLIES(a_class_place, clk, rst, m_tvalid && (r.status_class != CLS_OK),
    r.field_done && (r.byte_role == ROLE_OPSTAT))

  // An additional value comes from an empty name length
  `ASSERT_IMPLIES(a_addl_value, clk, rst, m_tvalid && r.additional_value,
    r.field_done && (r.byte_role == ROLE_NLEN) && (r.field_value == 32'd0))

  // Bad integer length only on a value length under an integer tag
  `ASSERT_IMPLIES(a_bad_len, clk, rst, m_tvalid && r.bad_integer_length,
    (r.byte_role == ROLE_VLEN) && (r.tag_kind == TT_INTEGER) && (r.field_value != 32'd4))

endmodule

bind ipp_message_byte_parser ipp_checker u_ipp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: verif/ipp_parse_checker.sv
// ----------------------------------------------------------------------------
// ipp_parse_checker
// Watches both streams of the IPP byte parser, predicts the result of every
// accepted byte from its own copy of the parse state and compares each
// result, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipp_parse_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [ipp_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
  input  logic                           s_tlast,   // last_byte
  input  logic [ipp_pkg::IN_USER_W-1:0]  s_tuser,   // [0] first_byte, [1] request_flag
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [ipp_pkg::OUT_DATA_W-1:0] m_tdata,   // result_t layout
  output int unsigned                    fail_count,
  output int unsigned                    pending
);
  import ipp_pkg::*;

  // Shadow parse state
  phase_t      pr_phase;
  logic [15:0] pr_count;
  logic [15:0] pr_vlen;
  logic [31:0] pr_acc;
  logic [7:0]  pr_tag;
  logic        pr_req;

  result_t     expected_roles[$];
  item_t       seen_byte;
  int unsigned mismatches = 0;

  assign fail_count = mismatches;

  function automatic void restart_parse();
    pr_phase = PH_VERSION;
    pr_count = '0;
    pr_vlen  = '0;
    pr_acc   = '0;
    pr_tag   = '0;
    pr_req   = 1'b0;
  endfunction

  // Shift a byte into a fixed-size field; high once the field is complete
  function automatic logic shift_field(input logic [7:0] b, input logic [15:0] size);
    if (pr_count == 16'd0) pr_acc = {24'd0, b};
    else pr_acc = {pr_acc[23:0], b};
    pr_count = pr_count + 16'd1;
    if (pr_count >= size) begin
      pr_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] class_of_code(input logic [15:0] code);
    case (code[15:8])
      CODE_OK:       return CLS_OK;
      CODE_INFO:     return CLS_INFO;
      CODE_REDIRECT: return CLS_REDIRECT;
      CODE_CLIENT:   return CLS_CLIENT;
      CODE_SERVER:   return CLS_SERVER;
      default:       return CLS_UNKNOWN;
    endcase
  endfunction

  function automatic logic [2:0] kind_of_tag(input logic [7:0] tag);
    case (tag[7:4])
      NIB_DELIM:   return TT_DELIM;
      NIB_INTEGER: return TT_INTEGER;
      NIB_OCTET:   return TT_OCTET;
      NIB_CHAR:    return TT_CHAR;
      default:     return TT_OTHER;
    endcase
  endfunction

  function automatic result_t classify_byte(input item_t it);
    result_t    r;
    logic [7:0] b;
    r = '0;
    r.byte_role = ROLE_TRAIL;
    b = it.data_byte;
    if (it.first_byte) begin
      restart_parse();
      pr_req = it.request_flag;
    end
    case (pr_phase)
      PH_VERSION: begin
        r.byte_role = ROLE_VERSION;
        if (shift_field(b, SIZE_SHORT)) begin
          r.field_done  = 1'b1;
          r.field_value = pr_acc;
          pr_phase      = PH_OPSTAT;
        end
      end
      PH_OPSTAT: begin
        r.byte_role = ROLE_OPSTAT;
        if (shift_field(b, SIZE_SHORT)) begin
          r.field_done  = 1'b1;
          r.field_value = pr_acc;
          if (!pr_req) r.status_class = class_of_code(pr_acc[15:0]);
          pr_phase = PH_REQID;
        end
      end
      PH_REQID: begin
        r.byte_role = ROLE_REQID;
        if (shift_field(b, SIZE_LONG)) begin
          r.field_done  = 1'b1;
          r.field_value = pr_acc;
          pr_phase      = PH_TAG;
        end
      end
      PH_TAG: begin
        pr_tag = b;
        if (b[7:4] == NIB_DELIM) begin
          if (b == TAG_END) begin
            r.byte_role = ROLE_END;
            pr_phase    = PH_TRAIL;
          end else begin
            r.byte_role = ROLE_GROUP;
          end
        end else begin
          r.byte_role = ROLE_VTAG;
          pr_count    = '0;
          pr_phase    = PH_NLEN;
        end
      end
      PH_NLEN: begin
        r.byte_role = ROLE_NLEN;
        if (shift_field(b, SIZE_SHORT)) begin
          r.field_done  = 1'b1;
          r.field_value = pr_acc;
          if (pr_acc == 32'd0) begin
            r.additional_value = 1'b1;
            pr_phase = PH_VLEN;
          end else begin
            pr_count = pr_acc[15:0];
            pr_phase = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        r.byte_role = ROLE_NAME;
        if (pr_count <= 16'd1) begin
          pr_count = '0;
          pr_phase = PH_VLEN;
        end else begin
          pr_count = pr_count - 16'd1;
        end
      end
      PH_VLEN: begin
        r.byte_role = ROLE_VLEN;
        if (shift_field(b, SIZE_SHORT)) begin
          r.field_done  = 1'b1;
          r.field_value = pr_acc;
          pr_vlen       = pr_acc[15:0];
          if (pr_tag[7:4] == NIB_INTEGER && pr_vlen != SIZE_LONG) r.bad_integer_length = 1'b1;
          if (pr_vlen == 16'd0) begin
            pr_phase = PH_TAG;
          end else begin
            pr_count = pr_vlen;
            pr_acc   = '0;
            pr_phase = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        r.byte_role = ROLE_VALUE;
        pr_acc = {pr_acc[23:0], b};
        if (pr_count <= 16'd1) begin
          pr_count = '0;
          if (pr_tag[7:4] == NIB_INTEGER && pr_vlen == SIZE_LONG) begin
            r.field_done  = 1'b1;
            r.field_value = pr_acc;
          end
          pr_phase = PH_TAG;
        end else begin
          pr_count = pr_count - 16'd1;
        end
      end
      default: r.byte_role = ROLE_TRAIL;
    endcase
    if (it.last_byte && pr_phase != PH_TAG && pr_phase < PH_TRAIL) r.truncated = 1'b1;
    r.tag_kind = kind_of_tag(pr_tag);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_result(input logic [OUT_DATA_W-1:0] word);
    result_t got;
    result_t want;
    got = result_t'(word);
    if (expected_roles.size() == 0) begin
      report_mismatch("result with nothing expected", word[31:0], 32'd0);
      return;
    end
    want = expected_roles.pop_front();
    if (got.byte_role !== want.byte_role)
      report_mismatch("byte_role", 32'(got.byte_role), 32'(want.byte_role));
    if (got.field_done !== want.field_done)
      report_mismatch("field_done", 32'(got.field_done), 32'(want.field_done));
    if (got.field_value !== want.field_value)
      report_mismatch("field_value", got.field_value, want.field_value);
    if (got.status_class !== want.status_class)
      report_mismatch("status_class", 32'(got.status_class), 32'(want.status_class));
    if (got.tag_kind !== want.tag_kind)
      report_mismatch("tag_kind", 32'(got.tag_kind), 32'(want.tag_kind));
    if (got.additional_value !== want.additional_value)
      report_mismatch("additional_value", 32'(got.additional_value),
                      32'(want.additional_value));
    if (got.bad_integer_length !== want.bad_integer_length)
      report_mismatch("bad_integer_length", 32'(got.bad_integer_length),
                      32'(want.bad_integer_length));
    if (got.truncated !== want.truncated)
      report_mismatch("truncated", 32'(got.truncated), 32'(want.truncated));
    if (got.pad !== 2'b00)
      report_mismatch("padding bits", 32'(got.pad), 32'd0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      expected_roles.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        seen_byte.data_byte    = s_tdata[7:0];
        seen_byte.first_byte   = s_tuser[0];
        seen_byte.last_byte    = s_tlast;
        seen_byte.request_flag = s_tuser[1];
        expected_roles.push_back(classify_byte(seen_byte));
      end
      if (m_tvalid && m_tready) compare_result(m_tdata);
    end
    pending = expected_roles.size();
  end

endmodule

// File: verif/tb_ipp_message_byte_parser.sv
// ----------------------------------------------------------------------------
// tb_ipp_message_byte_parser
// Feeds the IPP byte parser with whole, cut short, oversized and noisy
// messages under random bursts and output stalls; a checker alongside
// predicts each byte's result and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ipp_message_byte_parser;

  import ipp_pkg::*;

  // Stop once this many items have been accepted
  localparam int unsigned ITEM_TARGET = 1250;
  // Drain the parser completely once around here
  localparam int unsigned PAUSE_AT    = 450;
  // Hold the output off for a long stretch once around here
  localparam int unsigned HOLD_AT     = 850;
  localparam int unsigned HOLD_CYCLES = 300;
  // Settling margin once every result is back
  localparam int unsigned TAIL_CYCLES = 10;
  // Cycles without any handshake before giving up
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_GAP     = 12;
  localparam int unsigned MAX_BURST   = 40;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [7:0] data_byte
  logic                  s_tlast;   // last_byte
  logic [IN_USER_W-1:0]  s_tuser;   // [0] first_byte, [1] request_flag
  logic                  m_tvalid;
  logic                  m_tready;
  // [3:0] byte_role, [4] field_done, [36:5] field_value, [39:37] status_class,
  // [42:40] tag_kind, [43] additional_value, [44] bad_integer_length,
  // [45] truncated, [47:46] zero
  logic [OUT_DATA_W-1:0] m_tdata;

  int unsigned fail_count;
  int unsigned pending;

  // Bytes of the frame being assembled, sent in order
  item_t       frame_q[$];
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  bit          steady_send = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;

  ipp_message_byte_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ipp_parse_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if neither side moves an item for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: switch between stall patterns after each random span, and
  // take the one long hold-off when the stimulus asks for it
  initial begin
    int unsigned mode;
    int unsigned span;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk);
        if (hold_req && !hold_taken) begin
          // Hold off so the parser fills up and backs up its input
          m_tready   <= 1'b0;
          hold_taken = 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 0);
            2:       m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Offer one item and hold it until accepted; open a random gap between
  // bursts unless the sender is told to keep going
  task automatic push_item(input item_t it);
    int unsigned gap;
    if (burst_left == 0 && !steady_send) begin
      gap = $urandom_range(1, MAX_GAP);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, MAX_BURST);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it.data_byte;
    s_tlast  <= it.last_byte;
    s_tuser  <= {it.request_flag, it.first_byte};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[k]) push_item(frame_q[k]);
  endtask

  // Stop offering, wait until every result is back, then let the pipe settle
  task automatic drain_parser();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic put(input logic [7:0] b, input bit first, input bit last, input bit req);
    item_t it;
    it.data_byte    = b;
    it.first_byte   = first;
    it.last_byte    = last;
    it.request_flag = req;
    frame_q.push_back(it);
  endtask

  // Plain body byte; the request flag toggles freely since only the first byte counts
  task automatic add_byte(input logic [7:0] b);
    put(b, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // Append a big-endian field
  task automatic add_field(input logic [31:0] v, input int nbytes);
    for (int k = nbytes - 1; k >= 0; k--) add_byte(v[8*k +: 8]);
  endtask

  task automatic add_header();
    logic [15:0] ver;
    logic [7:0]  code_hi;
    case ($urandom_range(0, 2))
      0:       ver = 16'h0101;
      1:       ver = 16'h0200;
      default: ver = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 5))
      0:       code_hi = CODE_OK;
      1:       code_hi = CODE_INFO;
      2:       code_hi = CODE_REDIRECT;
      3:       code_hi = CODE_CLIENT;
      4:       code_hi = CODE_SERVER;
      default: code_hi = 8'($urandom_range(0, 255));
    endcase
    add_field({16'd0, ver}, 2);
    add_field({16'd0, code_hi, 8'($urandom_range(0, 255))}, 2);
    add_field($urandom, 4);
  endtask

  function automatic logic [7:0] pick_value_tag();
    logic [3:0] lo;
    lo = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 5))
      0, 1:    return {NIB_INTEGER, lo};
      2:       return {NIB_OCTET, lo};
      3:       return {NIB_CHAR, lo};
      4:       return {4'h1, lo};
      default: return {4'($urandom_range(5, 15)), lo};
    endcase
  endfunction

  // One attribute: tag, name length, name, value length, value
  task automatic add_attribute();
    logic [7:0]  tag;
    int unsigned nlen;
    int unsigned vlen;
    tag  = pick_value_tag();
    nlen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
    if (tag[7:4] == NIB_INTEGER)
      vlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 4;
    else
      vlen = $urandom_range(0, 6);
    add_byte(tag);
    add_field(nlen, 2);
    repeat (nlen) add_byte(8'($urandom_range(0, 255)));
    add_field(vlen, 2);
    repeat (vlen) add_byte(8'($urandom_range(0, 255)));
  endtask

  // Set the first mark on the opening byte and the last mark on the final one
  task automatic mark_frame(input bit req);
    frame_q[0].first_byte   = 1'b1;
    frame_q[0].request_flag = req;
    frame_q[frame_q.size() - 1].last_byte = 1'b1;
  endtask

  // Well-formed message with random content, optionally cut short
  task automatic build_message(input bit req, input bit cut);
    logic [7:0]  delim;
    int unsigned keep;
    frame_q.delete();
    add_header();
    repeat ($urandom_range(1, 3)) begin
      delim = 8'($urandom_range(0, 15));
      if (delim == TAG_END) delim = 8'h01;
      add_byte(delim);
      repeat ($urandom_range(0, 3)) add_attribute();
    end
    // Mostly close the attributes; otherwise the frame ends awaiting a tag
    if ($urandom_range(0, 7) != 0) begin
      add_byte(TAG_END);
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
    end
    if (cut) begin
      keep = $urandom_range(1, frame_q.size());
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end
    mark_frame(req);
    // Now and then a stray last mark mid-frame; parsing carries on past it
    if ($urandom_range(0, 5) == 0)
      frame_q[$urandom_range(0, frame_q.size() - 1)].last_byte = 1'b1;
  endtask

  // Name or value length far beyond what follows, frame ends inside it
  task automatic build_oversize(input bit req);
    logic [15:0] huge;
    frame_q.delete();
    add_header();
    huge = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(7, 65534));
    add_byte(($urandom_range(0, 1) == 0) ? pick_value_tag()
                                         : {NIB_INTEGER, 4'($urandom_range(0, 15))});
    if ($urandom_range(0, 1) == 0) begin
      add_field({16'd0, huge}, 2);
    end else begin
      add_field(32'd1, 2);
      add_byte(8'($urandom_range(0, 255)));
      add_field({16'd0, huge}, 2);
    end
    repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
    mark_frame(req);
  endtask

  // Short run of random bytes with random marks, often continuing a parse
  task automatic build_noise();
    frame_q.delete();
    repeat ($urandom_range(1, 10))
      put(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
          $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned pick;
    bit          paused;
    paused   = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    s_tuser  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: no first mark, so parse from reset as a response; all-ones
    // header, server-error status, integer tag with a zero name length (an
    // additional value) and a zero value length (bad length, straight back
    // to a tag), end tag, then a trailing byte carrying the last mark
    frame_q.delete();
    put(8'hFF, 0, 0, 1); put(8'hFF, 0, 0, 1);
    put(8'h05, 0, 0, 1); put(8'h00, 0, 0, 1);
    put(8'hFF, 0, 0, 1); put(8'hFF, 0, 0, 1); put(8'hFF, 0, 0, 1); put(8'hFF, 0, 0, 1);
    put(8'h21, 0, 0, 1);
    put(8'h00, 0, 0, 0); put(8'h00, 0, 0, 0);
    put(8'h00, 0, 0, 0); put(8'h00, 0, 0, 0);
    put(TAG_END, 0, 0, 0);
    put(8'hAA, 0, 1, 0);
    // Directed: request with an all-zero header and a proper four-byte
    // integer value whose last byte closes the frame
    put(8'h00, 1, 0, 1); put(8'h00, 0, 0, 0);
    put(8'h00, 0, 0, 0); put(8'h00, 0, 0, 0);
    put(8'h00, 0, 0, 0); put(8'h00, 0, 0, 0); put(8'h00, 0, 0, 0); put(8'h00, 0, 0, 0);
    put(8'h2F, 0, 0, 0);
    put(8'h00, 0, 0, 0); put(8'h01, 0, 0, 0); put(8'h80, 0, 0, 0);
    put(8'h00, 0, 0, 0); put(8'h04, 0, 0, 0);
    put(8'h7F, 0, 0, 0); put(8'hFF, 0, 0, 0); put(8'hFF, 0, 0, 0); put(8'hFF, 0, 1, 0);
    send_frame();
    drain_parser();

    // Random: mostly whole messages, some cut short, oversized or noise
    while (items_sent < ITEM_TARGET) begin
      if (!paused && items_sent >= PAUSE_AT) begin
        drain_parser();
        paused = 1'b1;
      end
      if (!hold_req && items_sent >= HOLD_AT) begin
        // Keep offering without gaps while the receiver holds off
        hold_req    = 1'b1;
        steady_send = 1'b1;
        build_message(1'($urandom_range(0, 1)), 1'b0);
        send_frame();
        build_message(1'($urandom_range(0, 1)), 1'b0);
        send_frame();
        steady_send = 1'b0;
      end
      pick = $urandom_range(0, 19);
      if (pick < 13) build_message(1'($urandom_range(0, 1)), 1'b0);
      else if (pick < 16) build_message(1'($urandom_range(0, 1)), 1'b1);
      else if (pick < 18) build_oversize(1'($urandom_range(0, 1)));
      else build_noise();
      send_frame();
    end

    drain_parser();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
